[sv/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants and types of the modular exponentiation block: default
// operand width, multiplier operand selection and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // Default operand width in bits
  localparam int unsigned WIDTH_DEF = 32;

  // Operand selection for the shared modular multiplier
  typedef enum logic [1:0] {
    OP_REDUCE,  // 1 * base mod n, i.e. base mod n
    OP_MUL,     // accumulator * square mod n
    OP_SQR      // square * square mod n
  } mexp_op_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     load;         // capture a new transaction
    logic     start;        // launch the multiplier
    mexp_op_e op;           // operands for the launch
    logic     take_reduce;  // store the reduced base
    logic     take_mul;     // store the new accumulator
    logic     take_sqr;     // store the new square, consume one exponent bit
    logic     load_out;     // move the accumulator into the output register
  } mexp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic n_small;   // modulus below two
    logic rem_zero;  // no exponent bits left
    logic rem_lsb;   // current exponent bit
    logic mul_done;  // multiplier result ready
  } mexp_sts_t;

endpackage

[sv/mexp_mulmod.sv]
// ----------------------------------------------------------------------------
// mexp_mulmod
// Interleaved modular multiplier: r = a * b mod n, one bit of b per cycle,
// most significant bit first. Needs a < n; b may take any value.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
  parameter int unsigned WIDTH = mexp_pkg::WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic [WIDTH-1:0] n_i,
  output logic             done_o,
  output logic [WIDTH-1:0] r_o
);
  import mexp_pkg::*;

  localparam int unsigned EW = WIDTH + 3;
  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] r_q, r_d, b_q;
  logic [EW-1:0]    a_q, amn_q, a2n_q;
  logic [CW-1:0]    cnt_q;
  logic             done_q;

  logic [EW-1:0] n_ext, n2_ext, a_ext;
  logic [EW-1:0] d0, d1, e0, e1, e2, pick;

  assign n_ext  = {3'b000, n_i};
  assign n2_ext = {2'b00, n_i, 1'b0};
  assign a_ext  = {3'b000, a_i};

  // Double the partial result, adding the multiplicand on a set bit of b;
  // each candidate is one adder deep, the smallest non-negative one wins
  always_comb begin
    d0 = {2'b00, r_q, 1'b0};
    d1 = d0 - n_ext;
    e0 = d0 + a_q;
    e1 = d0 + amn_q;
    e2 = d0 + a2n_q;
    if (b_q[WIDTH-1]) begin
      if (!e2[EW-1]) begin
        pick = e2;
      end else if (!e1[EW-1]) begin
        pick = e1;
      end else begin
        pick = e0;
      end
    end else begin
      if (!d1[EW-1]) begin
        pick = d1;
      end else begin
        pick = d0;
      end
    end
    r_d = pick[WIDTH-1:0];
  end

  // Hold the bit counter and completion flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(WIDTH);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - CW'(1);
        done_q <= (cnt_q == CW'(1));
      end
    end
  end

  // Advance the operands and partial result
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= '0;
      b_q   <= b_i;
      a_q   <= a_ext;
      amn_q <= a_ext - n_ext;
      a2n_q <= a_ext - n2_ext;
    end else if (cnt_q != '0) begin
      r_q <= r_d;
      b_q <= {b_q[WIDTH-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign r_o    = r_q;

endmodule

[sv/mexp_datapath.sv]
// ----------------------------------------------------------------------------
// mexp_datapath
// Accumulator, running square and remaining exponent of the square-and-
// multiply loop, the shared modular multiplier and the output register.
// ----------------------------------------------------------------------------
module mexp_datapath #(
  parameter int unsigned WIDTH = mexp_pkg::WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mexp_pkg::mexp_cmd_t cmd_i,
  output mexp_pkg::mexp_sts_t sts_o,
  input  logic [WIDTH-1:0]    base_value_i,
  input  logic [WIDTH-1:0]    modulus_i,
  input  logic [WIDTH-1:0]    exponent_i,
  output logic [WIDTH-1:0]    power_result_o
);
  import mexp_pkg::*;

  logic [WIDTH-1:0] acc_q, sq_q, rem_q, result_q;
  logic [WIDTH-1:0] mul_a, mul_b, mul_r;
  logic             mul_done;
  logic             n_small;

  assign n_small = (modulus_i < WIDTH'(2));

  // Select multiplier operands
  always_comb begin
    case (cmd_i.op)
      OP_REDUCE: begin
        mul_a = WIDTH'(1);
        mul_b = base_value_i;
      end
      OP_MUL: begin
        mul_a = acc_q;
        mul_b = sq_q;
      end
      OP_SQR: begin
        mul_a = sq_q;
        mul_b = sq_q;
      end
      default: begin
        mul_a = sq_q;
        mul_b = sq_q;
      end
    endcase
  end

  mexp_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .n_i     (modulus_i),
    .done_o  (mul_done),
    .r_o     (mul_r)
  );

  // Update loop state on controller commands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      sq_q     <= '0;
      rem_q    <= '0;
      result_q <= '0;
    end else begin
      if (cmd_i.load) begin
        acc_q <= '0;
        rem_q <= n_small ? '0 : exponent_i;
      end
      if (cmd_i.take_reduce) begin
        sq_q <= mul_r;
        if (mul_r == '0) begin
          rem_q <= '0;
        end else begin
          acc_q <= WIDTH'(1);
        end
      end
      if (cmd_i.take_mul) begin
        acc_q <= mul_r;
      end
      if (cmd_i.take_sqr) begin
        sq_q  <= mul_r;
        rem_q <= rem_q >> 1;
      end
      if (cmd_i.load_out) begin
        result_q <= acc_q;
      end
    end
  end

  assign sts_o.n_small  = n_small;
  assign sts_o.rem_zero = (rem_q == '0);
  assign sts_o.rem_lsb  = rem_q[0];
  assign sts_o.mul_done = mul_done;

  assign power_result_o = result_q;

endmodule

[sv/mexp_ctrl.sv]
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer of the square-and-multiply loop: accepts a transaction, walks
// the exponent bits through the shared multiplier and hands the result to
// the output register.
// ----------------------------------------------------------------------------
module mexp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mexp_pkg::mexp_cmd_t cmd_o,
  input  mexp_pkg::mexp_sts_t sts_i
);
  import mexp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_LOOP,
    S_MUL,
    S_SQR,
    S_DONE
  } state_e;

  state_e    state_q, state_d;
  logic      out_valid_q, out_valid_d;
  mexp_cmd_t cmd;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    cmd.op  = OP_REDUCE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          if (sts_i.n_small) begin
            state_d = S_LOOP;
          end else begin
            cmd.start = 1'b1;
            cmd.op    = OP_REDUCE;
            state_d   = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (sts_i.mul_done) begin
          cmd.take_reduce = 1'b1;
          state_d         = S_LOOP;
        end
      end
      S_LOOP: begin
        if (sts_i.rem_zero) begin
          state_d = S_DONE;
        end else if (sts_i.rem_lsb) begin
          cmd.start = 1'b1;
          cmd.op    = OP_MUL;
          state_d   = S_MUL;
        end else begin
          cmd.start = 1'b1;
          cmd.op    = OP_SQR;
          state_d   = S_SQR;
        end
      end
      S_MUL: begin
        if (sts_i.mul_done) begin
          cmd.take_mul = 1'b1;
          cmd.start    = 1'b1;
          cmd.op       = OP_SQR;
          state_d      = S_SQR;
        end
      end
      S_SQR: begin
        if (sts_i.mul_done) begin
          cmd.take_sqr = 1'b1;
          state_d      = S_LOOP;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Load the output slot, drop it once taken
  always_comb begin
    if (cmd.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Hold state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

[sv/modular_exponentiation.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation
// Raises each base to the configured exponent modulo the configured modulus
// by right-to-left binary square-and-multiply.
// ----------------------------------------------------------------------------
// Usage:
//   Configure modulus (address 0) and exponent (address 4) over the APB port
//   while no transaction is in flight; both read back. Reset leaves modulus 2
//   and exponent 1.
//   Input channel: base_value_i with in_valid_i / in_ready_o. Output channel:
//   power_result_o with out_valid_o / out_ready_i, one result per base.
//   One transaction is processed at a time. Every multiply or square runs on
//   a single shared interleaved multiplier at one bit per cycle. The base is
//   first reduced modulo the modulus; then, for each exponent bit up to the
//   highest set one, the square is updated, preceded by a multiply of the
//   accumulator where that bit is set. A zero base or modulus below two
//   finishes after the reduction or at once.
//   The result sits in an output register; in_ready_o rises again as soon as
//   it is loaded, so the next base is taken while the receiver stalls. A new
//   result waits for the output register to empty. Reset drops any pending
//   result and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int unsigned WIDTH  = mexp_pkg::WIDTH_DEF,
  parameter int unsigned DATA_W = (WIDTH > 32) ? 64 : 32,
  parameter int unsigned ADDR_W = (WIDTH > 32) ? 4 : 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic [WIDTH-1:0]  base_value_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  // output channel
  output logic [WIDTH-1:0]  power_result_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);
  import mexp_pkg::*;

  localparam logic REG_MODULUS  = 1'b0;
  localparam logic REG_EXPONENT = 1'b1;

  logic [WIDTH-1:0] modulus_q, exponent_q;
  logic             cfg_write;
  logic             reg_sel;
  mexp_cmd_t        cmd;
  mexp_sts_t        sts;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[ADDR_W-1];
  assign cfg_write = psel && penable && pwrite && pready;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= WIDTH'(2);
      exponent_q <= WIDTH'(1);
    end else if (cfg_write) begin
      if (reg_sel == REG_MODULUS) begin
        modulus_q <= pwdata[WIDTH-1:0];
      end else begin
        exponent_q <= pwdata[WIDTH-1:0];
      end
    end
  end

  // Read back the selected register
  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_MODULUS:  prdata[WIDTH-1:0] = modulus_q;
      REG_EXPONENT: prdata[WIDTH-1:0] = exponent_q;
      default:      prdata = '0;
    endcase
  end

  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mexp_datapath #(.WIDTH(WIDTH)) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .base_value_i   (base_value_i),
    .modulus_i      (modulus_q),
    .exponent_i     (exponent_q),
    .power_result_o (power_result_o)
  );

endmodule

[sv/mexp_checker.sv]
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks of the modular exponentiation block, bound to the top.
// ----------------------------------------------------------------------------
module mexp_checker #(
  parameter int unsigned WIDTH  = mexp_pkg::WIDTH_DEF,
  parameter int unsigned DATA_W = (WIDTH > 32) ? 64 : 32,
  parameter int unsigned ADDR_W = (WIDTH > 32) ? 4 : 3
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [WIDTH-1:0]  power_result_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic              pready
);
  import mexp_pkg::*;

  logic [WIDTH-1:0] mod_q;
  logic             in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  // Track the modulus from completed writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= WIDTH'(2);
    end else if (psel && penable && pwrite && pready && !paddr[ADDR_W-1]) begin
      mod_q <= pwdata[WIDTH-1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(power_result_o))
    else $error("result changed while stalled");

  a_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mod_q >= WIDTH'(2)) |-> power_result_o < mod_q)
    else $error("result not reduced below modulus");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("new base taken while one is in flight");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_acc))
    else $error("result appeared the cycle after acceptance");

endmodule

bind modular_exponentiation mexp_checker #(
  .WIDTH  (WIDTH),
  .DATA_W (DATA_W),
  .ADDR_W (ADDR_W)
) u_mexp_checker (.*);

[dv/modular_exponentiation_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// Self-checking bench for the modular exponentiation block. A short table of
// directed vectors covers reset values, modulus and exponent extremes and the
// zero-base and zero-exponent corners. Random settings phases with random
// bases follow, under random idling on both channels. Results are checked
// against the table or a 64-bit behavioural square-and-multiply model.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;

  localparam int unsigned WIDTH = mexp_pkg::WIDTH_DEF;
  // worst case: reduction and wrap-up plus a square and a multiply per bit
  localparam int MAX_LATENCY = (WIDTH + 4) + WIDTH * (2 * WIDTH + 3);
  localparam int CYCLE_LIMIT = 300 * (MAX_LATENCY + 200) * 4;
  localparam int N_DIRECTED  = 22;
  localparam int N_PHASES    = 10;
  localparam int PHASE_ITEMS = 27;

  // register map of the configuration port
  typedef enum logic [2:0] {
    REG_MODULUS  = 3'd0,
    REG_EXPONENT = 3'd4
  } reg_addr_e;

  // one directed vector; the result is only used where known is set
  typedef struct packed {
    logic [WIDTH-1:0] modulus;
    logic [WIDTH-1:0] exponent;
    logic [WIDTH-1:0] base;
    logic             known;
    logic [WIDTH-1:0] result;
  } vector_t;

  localparam vector_t DIRECTED [N_DIRECTED] = '{
    // reset settings: modulus 2, exponent 1
    '{32'd2, 32'd1, 32'h0000_0000, 1'b1, 32'd0},
    '{32'd2, 32'd1, 32'h0000_0001, 1'b1, 32'd1},
    '{32'd2, 32'd1, 32'hFFFF_FFFF, 1'b1, 32'd1},
    '{32'd2, 32'd1, 32'hFFFF_FFFE, 1'b1, 32'd0},
    // modulus below two always answers zero
    '{32'd0, 32'd5, 32'h0000_1234, 1'b1, 32'd0},
    '{32'd1, 32'd5, 32'hFFFF_FFFF, 1'b1, 32'd0},
    '{32'd1, 32'd0, 32'h0000_0000, 1'b1, 32'd0},
    // exponent zero to two, with and without a multiple of the modulus
    '{32'd13, 32'd0, 32'd5,   1'b1, 32'd1},
    '{32'd13, 32'd0, 32'd26,  1'b1, 32'd0},
    '{32'd13, 32'd1, 32'd100, 1'b1, 32'd9},
    '{32'd13, 32'd2, 32'd100, 1'b1, 32'd3},
    // largest modulus, with the largest exponent and with two
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'd0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'd1},
    '{32'hFFFF_FFFF, 32'd2,         32'hFFFF_FFFE, 1'b1, 32'd1},
    // largest 32-bit prime with Fermat exponent p-1, then mixed cases
    '{32'hFFFF_FFFB, 32'hFFFF_FFFA, 32'h0000_0003, 1'b1, 32'd1},
    '{32'hFFFF_FFFB, 32'hFFFF_FFFA, 32'hDEAD_BEEF, 1'b1, 32'd1},
    '{32'hFFFF_FFFB, 32'h0001_0001, 32'hDEAD_BEEF, 1'b0, 32'd0},
    '{32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0003, 1'b0, 32'd0},
    '{32'h8000_0000, 32'd3,         32'h8000_0000, 1'b1, 32'd0},
    '{32'd3,         32'hFFFF_FFFF, 32'd2,         1'b1, 32'd2}
  };

  logic             clk_i;
  logic             rst_ni;
  logic [WIDTH-1:0] base_value_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [WIDTH-1:0] power_result_o;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  // predictor copy of the configuration
  logic [WIDTH-1:0] cfg_modulus  = 32'd2;
  logic [WIDTH-1:0] cfg_exponent = 32'd1;

  logic [WIDTH-1:0] pending_powers [$];
  logic [WIDTH-1:0] oldest_power;
  int unsigned      mismatches    = 0;
  int unsigned      results_seen  = 0;
  int unsigned      bases_sent    = 0;
  int unsigned      settings_used = 1;
  int unsigned      cycle_count   = 0;
  bit               steady_sender = 1'b0;

  modular_exponentiation u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .base_value_i   (base_value_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .power_result_o (power_result_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Clock: 20 ns period
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Abort a run that hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
             pending_powers.size());
    $display("*** FAILED ***");
    $finish;
  end

  // base^exponent mod modulus by right-to-left square-and-multiply
  function automatic logic [WIDTH-1:0] mod_power(logic [WIDTH-1:0] base,
                                                 logic [WIDTH-1:0] modulus,
                                                 logic [WIDTH-1:0] exponent);
    logic [63:0]      product;
    logic [63:0]      square;
    logic [WIDTH-1:0] bits_left;
    if (modulus < 2) return '0;
    square = 64'(base % modulus);
    if (square == 0) return '0;
    product   = 64'd1;
    bits_left = exponent;
    while (bits_left != 0) begin
      if (bits_left[0]) product = (product * square) % modulus;
      square    = (square * square) % modulus;
      bits_left = bits_left >> 1;
    end
    return product[WIDTH-1:0];
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic note_mismatch(string what, logic [WIDTH-1:0] want,
                               logic [WIDTH-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch (%s) at cycle %0d: expected %h, got %h",
               what, cycle_count, want, got);
    end
  endtask

  // Check each result transaction against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_powers.size() == 0) begin
        note_mismatch("result with nothing pending", '0, power_result_o);
      end else begin
        oldest_power = pending_powers.pop_front();
        results_seen++;
        if (power_result_o !== oldest_power) begin
          note_mismatch("power_result", oldest_power, power_result_o);
        end
      end
    end
  end

  // Receiver: ready stretches broken by random stalls
  initial begin
    int unsigned hold;
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold  = ($urandom_range(0, 9) == 0) ? 400 : $urandom_range(1, 30);
      stall = idle_gap();
      @(negedge clk_i);
      out_ready_i = 1'b1;
      repeat (hold - 1) @(negedge clk_i);
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
    end
  end

  // Write a register, read it back and update the predictor
  task automatic set_register(reg_addr_e addr, logic [31:0] value);
    logic [31:0] readback;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    readback = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    case (addr)
      REG_MODULUS:  cfg_modulus  = value;
      REG_EXPONENT: cfg_exponent = value;
      default: ;
    endcase
    if (readback !== value) note_mismatch("register readback", value, readback);
  endtask

  // Drop valid and hold until every pending result has arrived
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_powers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Offer one base, record its expected power, then idle for a random gap
  task automatic send_base(logic [WIDTH-1:0] base, logic known,
                           logic [WIDTH-1:0] result);
    int unsigned gap;
    @(negedge clk_i);
    base_value_i = base;
    in_valid_i   = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_powers.push_back(known ? result : mod_power(base, cfg_modulus, cfg_exponent));
    bases_sent++;
    gap = steady_sender ? 0 : idle_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  initial begin : stimulus
    vector_t          row;
    logic [WIDTH-1:0] modulus;
    logic [WIDTH-1:0] exponent;
    logic [WIDTH-1:0] base;

    rst_ni       = 1'b0;
    base_value_i = '0;
    in_valid_i   = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed vectors; reconfigure only once the block has gone idle
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (row.modulus != cfg_modulus || row.exponent != cfg_exponent) begin
        drain_results();
        if (row.modulus != cfg_modulus) set_register(REG_MODULUS, row.modulus);
        if (row.exponent != cfg_exponent) set_register(REG_EXPONENT, row.exponent);
        settings_used++;
      end
      send_base(row.base, row.known, row.result);
    end

    // Random settings phases
    for (int p = 0; p < N_PHASES; p++) begin
      case ($urandom_range(0, 9))
        0:       modulus = $urandom_range(0, 1);
        1, 2:    modulus = $urandom_range(2, 255);
        3, 4, 5: modulus = $urandom;
        6:       modulus = 32'hFFFF_FFFF - $urandom_range(0, 15);
        7:       modulus = 32'd1 << $urandom_range(1, 31);
        default: modulus = $urandom_range(2, 65535);
      endcase
      case ($urandom_range(0, 9))
        0:       exponent = '0;
        1, 2, 3: exponent = $urandom_range(1, 31);
        4, 5, 6: exponent = $urandom_range(0, 65535);
        7, 8:    exponent = $urandom;
        default: exponent = 32'hFFFF_FFFF;
      endcase
      drain_results();
      set_register(REG_MODULUS, modulus);
      set_register(REG_EXPONENT, exponent);
      settings_used++;
      steady_sender = ($urandom_range(0, 3) == 0);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // now and then hold off until the pipeline is empty
        if ($urandom_range(0, 29) == 0) drain_results();
        case ($urandom_range(0, 9))
          0: base = '0;
          1: base = (cfg_modulus > 1) ?
                    cfg_modulus * $urandom_range(0, 32'hFFFF_FFFF / cfg_modulus) : $urandom;
          2: base = cfg_modulus - 1;
          3: base = cfg_modulus;
          default: base = $urandom;
        endcase
        send_base(base, 1'b0, '0);
      end
    end

    // Wait out the tail and watch for stray results
    drain_results();
    repeat (MAX_LATENCY) @(posedge clk_i);

    $display("Ran %0d bases over %0d modulus/exponent settings, %0d results checked",
             bases_sent, settings_used, results_seen);
    $display("Mismatches: %0d, results outstanding: %0d", mismatches,
             pending_powers.size());
    if (mismatches == 0 && pending_powers.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/mexp_pkg.sv
sv/mexp_mulmod.sv
sv/mexp_datapath.sv
sv/mexp_ctrl.sv
sv/modular_exponentiation.sv
sv/mexp_checker.sv
dv/modular_exponentiation_tb.sv
